// ===== rtl/ists_pkg.sv =====
// ists_pkg: shared types, constants and lookup functions for the timestamp to
// epoch seconds unit. No dependencies; every file but ists_if imports it.
`default_nettype none

package ists_pkg;

   // text layout
   localparam int unsigned TS_LEN = 19;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_T     = 8'h54;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   // year offset keeps the shifted year positive (three whole 400-year eras)
   localparam int unsigned YEAR_BIAS  = 1200;
   localparam int unsigned ERA_BIAS   = 3;
   // floor(x / 400) as (x * RECIP_400) >> RECIP_SHIFT, exact for x < 2^14
   localparam int unsigned RECIP_400   = 20972;
   localparam int unsigned RECIP_SHIFT = 23;
   localparam int unsigned DAYS_PER_ERA = 146097;
   localparam int unsigned EPOCH_SHIFT  = 719468;
   localparam int unsigned SEC_PER_DAY  = 86400;

   // field owning each text position
   typedef enum logic [2:0] {
      FLD_YEAR,
      FLD_MONTH,
      FLD_DAY,
      FLD_HOUR,
      FLD_MINUTE,
      FLD_SECOND,
      FLD_SEP
   } field_type;

   // back-end sequencer
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DIV,
      BK_YOE,
      BK_DAYS,
      BK_MUL,
      BK_OUT
   } bk_state_type;

   // one parsed timestamp handed from front to back
   typedef struct packed {
      logic               ok;
      logic signed [14:0] year;
      logic [3:0]         month;
      logic [4:0]         day;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
   } date_type;

   function automatic field_type pos_field(input logic [4:0] pos);
      field_type f;
      case (pos)
         5'd0, 5'd1, 5'd2, 5'd3: f = FLD_YEAR;
         5'd5, 5'd6:             f = FLD_MONTH;
         5'd8, 5'd9:             f = FLD_DAY;
         5'd11, 5'd12:           f = FLD_HOUR;
         5'd14, 5'd15:           f = FLD_MINUTE;
         5'd17, 5'd18:           f = FLD_SECOND;
         default:                f = FLD_SEP;
      endcase
      return f;
   endfunction

   function automatic logic pos_first(input logic [4:0] pos);
      logic r;
      case (pos)
         5'd0, 5'd5, 5'd8, 5'd11, 5'd14, 5'd17: r = 1'b1;
         default:                               r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] pos_sep(input logic [4:0] pos);
      logic [7:0] c;
      case (pos)
         5'd4, 5'd7:   c = CH_MINUS;
         5'd10:        c = CH_T;
         5'd13, 5'd16: c = CH_COLON;
         default:      c = 8'h00;
      endcase
      return c;
   endfunction

   // days from march 1 to the first of the month, year starting in march
   function automatic logic [8:0] month_offset(input logic [3:0] month);
      logic [8:0] d;
      case (month)
         4'd3:    d = 9'd0;
         4'd4:    d = 9'd31;
         4'd5:    d = 9'd61;
         4'd6:    d = 9'd92;
         4'd7:    d = 9'd122;
         4'd8:    d = 9'd153;
         4'd9:    d = 9'd184;
         4'd10:   d = 9'd214;
         4'd11:   d = 9'd245;
         4'd12:   d = 9'd275;
         4'd1:    d = 9'd306;
         4'd2:    d = 9'd337;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/ists_if.sv =====
// ists_if: request and response channel interfaces (valid/ready plus payload).
// Depends on nothing; used by the front, back and top level.
`default_nettype none

interface ists_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last;

   modport source (output valid, output char_code, output last, input ready);
   modport sink (input valid, input char_code, input last, output ready);
endinterface

interface ists_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [38:0] epoch_seconds;
   logic               valid_res;

   modport source (output valid, output epoch_seconds, output valid_res, input ready);
   modport sink (input valid, input epoch_seconds, input valid_res, output ready);
endinterface

`default_nettype wire

// ===== rtl/ists_front.sv =====
// ists_front: character parser; checks separators and digits, collects fields,
// range-checks them and pushes one date per string. Uses ists_pkg, ists_req_if.
`default_nettype none

module ists_front
   import ists_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   ists_req_if.sink    req_chan,
   input  wire logic   q_full,
   output logic        push,
   output date_type    push_data
);

   logic [4:0] pos_ff, pos_in;
   logic [13:0] year_ff, year_in;
   logic [6:0] mon_ff, mon_in;
   logic [6:0] day_ff, day_in;
   logic [6:0] hour_ff, hour_in;
   logic [6:0] min_ff, min_in;
   logic [6:0] sec_ff, sec_in;
   logic [5:0] neg_ff, neg_in;
   logic       err_ff, err_in;

   logic       accept;
   field_type  kind;
   logic       is_digit;
   logic [3:0] digit;
   logic       fields_ok;

   assign req_chan.ready = !q_full;
   assign accept = req_chan.valid && req_chan.ready;
   assign kind = pos_field(pos_ff);
   assign is_digit = (req_chan.char_code >= CH_ZERO) && (req_chan.char_code <= CH_NINE);
   assign digit = req_chan.char_code[3:0];

   // per-character update
   always_comb begin
      pos_in  = pos_ff;
      year_in = year_ff;
      mon_in  = mon_ff;
      day_in  = day_ff;
      hour_in = hour_ff;
      min_in  = min_ff;
      sec_in  = sec_ff;
      neg_in  = neg_ff;
      err_in  = err_ff;
      if (accept && (pos_ff < 5'(TS_LEN))) begin
         if (kind == FLD_SEP) begin
            if (req_chan.char_code != pos_sep(pos_ff)) begin
               err_in = 1'b1;
            end
         end else if (is_digit) begin
            case (kind)
               FLD_YEAR:   year_in = 14'(year_ff * 14'd10 + 14'(digit));
               FLD_MONTH:  mon_in  = 7'(mon_ff * 7'd10 + 7'(digit));
               FLD_DAY:    day_in  = 7'(day_ff * 7'd10 + 7'(digit));
               FLD_HOUR:   hour_in = 7'(hour_ff * 7'd10 + 7'(digit));
               FLD_MINUTE: min_in  = 7'(min_ff * 7'd10 + 7'(digit));
               default:    sec_in  = 7'(sec_ff * 7'd10 + 7'(digit));
            endcase
         end else if ((req_chan.char_code == CH_MINUS) && pos_first(pos_ff)) begin
            neg_in[kind] = 1'b1;
         end else begin
            err_in = 1'b1;
         end
         pos_in = pos_ff + 5'd1;
      end
   end

   // range checks; a negative zero counts as zero for time fields
   assign fields_ok = !neg_in[FLD_MONTH] && (mon_in >= 7'd1) && (mon_in <= 7'd12)
                   && !neg_in[FLD_DAY] && (day_in >= 7'd1) && (day_in <= 7'd31)
                   && (neg_in[FLD_HOUR] ? (hour_in == 7'd0) : (hour_in <= 7'd23))
                   && (neg_in[FLD_MINUTE] ? (min_in == 7'd0) : (min_in <= 7'd59))
                   && (neg_in[FLD_SECOND] ? (sec_in == 7'd0) : (sec_in <= 7'd60));

   // push one date on the last character
   assign push = accept && req_chan.last;
   always_comb begin
      push_data.ok     = (pos_in >= 5'(TS_LEN)) && !err_in && fields_ok;
      push_data.year   = neg_in[FLD_YEAR] ? -$signed({1'b0, year_in})
                                          : $signed({1'b0, year_in});
      push_data.month  = mon_in[3:0];
      push_data.day    = day_in[4:0];
      push_data.hour   = hour_in[4:0];
      push_data.minute = min_in[5:0];
      push_data.second = sec_in[5:0];
   end

   // parse state, cleared after each string
   always_ff @(posedge clock) begin
      if (reset || push) begin
         pos_ff  <= '0;
         year_ff <= '0;
         mon_ff  <= '0;
         day_ff  <= '0;
         hour_ff <= '0;
         min_ff  <= '0;
         sec_ff  <= '0;
         neg_ff  <= '0;
         err_ff  <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         year_ff <= year_in;
         mon_ff  <= mon_in;
         day_ff  <= day_in;
         hour_ff <= hour_in;
         min_ff  <= min_in;
         sec_ff  <= sec_in;
         neg_ff  <= neg_in;
         err_ff  <= err_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/ists_queue.sv =====
// ists_queue: small first-in first-out buffer of parsed dates between the
// parser and the arithmetic sequencer. Uses ists_pkg.
`default_nettype none

module ists_queue
   import ists_pkg::*;
#(
   parameter int unsigned DEPTH = 2
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire date_type push_data,
   input  wire logic     pop,
   output date_type      head,
   output logic          full,
   output logic          not_empty
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   date_type           slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = slot_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("queue read while empty");

endmodule

`default_nettype wire

// ===== rtl/ists_back.sv =====
// ists_back: multi-cycle days-from-civil sequencer and response register.
// Uses ists_pkg and ists_rsp_if; takes dates from ists_queue.
`default_nettype none

module ists_back
   import ists_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire date_type head,
   input  wire logic     not_empty,
   output logic          pop,
   ists_rsp_if.source    rsp_chan
);

   bk_state_type       state_ff, state_in;
   logic               ok_ff;
   logic [13:0]        yy_ff;
   logic [8:0]         doy_ff;
   logic [16:0]        tod_ff;
   logic [4:0]         q_ff;
   logic [8:0]         yoe_ff;
   logic signed [22:0] era_days_ff;
   logic signed [22:0] days_ff;
   logic signed [38:0] prod_ff;
   logic               rsp_valid_ff;
   logic signed [38:0] rsp_epoch_ff;
   logic               rsp_ok_ff;

   logic               out_free;
   logic               load_out;
   logic signed [15:0] yy_wide;
   logic [27:0]        recip_prod;
   logic signed [22:0] era_ext;
   logic [1:0]         cent;
   logic [17:0]        doe;
   logic signed [39:0] days_prod;

   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer
   always_comb begin
      state_in = state_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         BK_IDLE: begin
            if (not_empty) begin
               pop      = 1'b1;
               state_in = BK_DIV;
            end
         end
         BK_DIV:  state_in = BK_YOE;
         BK_YOE:  state_in = BK_DAYS;
         BK_DAYS: state_in = BK_MUL;
         BK_MUL:  state_in = BK_OUT;
         BK_OUT: begin
            if (out_free) begin
               load_out = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // shifted year: march-based, biased positive
   assign yy_wide = 16'(head.year) + 16'(YEAR_BIAS)
                  - ((head.month <= 4'd2) ? 16'sd1 : 16'sd0);
   // era by reciprocal multiply
   assign recip_prod = 28'(yy_ff) * 28'(RECIP_400);
   assign era_ext = 23'($signed({1'b0, q_ff})) - 23'(ERA_BIAS);
   // year of era split into centuries
   assign cent = 2'((yoe_ff >= 9'd100) + (yoe_ff >= 9'd200) + (yoe_ff >= 9'd300));
   assign doe = 18'(yoe_ff) * 18'd365 + 18'(yoe_ff >> 2) - 18'(cent) + 18'(doy_ff);
   assign days_prod = 40'(days_ff) * 40'(SEC_PER_DAY);

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            ok_ff  <= head.ok;
            yy_ff  <= yy_wide[13:0];
            doy_ff <= 9'(month_offset(head.month) + 9'(head.day) - 9'd1);
            tod_ff <= 17'(17'(head.hour) * 17'd3600 + 17'(head.minute) * 17'd60
                        + 17'(head.second));
         end
         BK_DIV: begin
            q_ff <= recip_prod[RECIP_SHIFT +: 5];
         end
         BK_YOE: begin
            yoe_ff      <= 9'(yy_ff - 14'(q_ff) * 14'd400);
            era_days_ff <= 23'(era_ext * 23'(DAYS_PER_ERA));
         end
         BK_DAYS: begin
            days_ff <= era_days_ff + $signed({5'd0, doe}) - 23'(EPOCH_SHIFT);
         end
         BK_MUL: begin
            prod_ff <= days_prod[38:0];
         end
         default: begin
         end
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_epoch_ff <= ok_ff ? prod_ff + 39'(tod_ff) : '0;
         rsp_ok_ff    <= ok_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.epoch_seconds = rsp_epoch_ff;
   assign rsp_chan.valid_res     = rsp_ok_ff;

   a_fail_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ok_ff |-> rsp_epoch_ff == '0)
      else $error("failed parse carries nonzero seconds");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      (state_ff == BK_OUT) && out_free |=> rsp_valid_ff && (state_ff == BK_IDLE))
      else $error("finished date not presented");

   a_pop_starts: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == BK_DIV)
      else $error("dequeued date not started");

endmodule

`default_nettype wire

// ===== rtl/iso_timestamp_to_epoch_seconds_unit.sv =====
// iso_timestamp_to_epoch_seconds_unit: top level; parser, date queue and
// arithmetic sequencer. Uses ists_pkg, ists_if, ists_front, ists_queue, ists_back.
//
//   channel    dir  handshake      payload
//   req_chan   in   valid / ready  char_code[7:0], last
//   rsp_chan   out  valid / ready  epoch_seconds[38:0] signed, valid_res
//
// one request (character) per cycle while the date queue has room; a string's
// last request queues a parsed date; the sequencer turns one date at a time into
// seconds along its divide / era multiply / day multiply chain (DIV, YOE, DAYS, MUL)
// reset is synchronous and clears parser, queue and sequencer state
// req_chan.ready drops only while the date queue is full
// the response register frees the sequencer while a result waits on rsp_chan
`default_nettype none

module iso_timestamp_to_epoch_seconds_unit
   import ists_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  wire logic  clock,
   input  wire logic  reset,
   ists_req_if.sink   req_chan,
   ists_rsp_if.source rsp_chan
);

   logic     push;
   date_type push_data;
   logic     pop;
   date_type head;
   logic     q_full;
   logic     q_not_empty;

   ists_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .q_full    (q_full),
      .push      (push),
      .push_data (push_data)
   );

   ists_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .full      (q_full),
      .not_empty (q_not_empty)
   );

   ists_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .not_empty (q_not_empty),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== tb/iso_timestamp_to_epoch_seconds_unit_checker.sv =====
`timescale 1ns / 1ps
// iso_timestamp_to_epoch_seconds_unit_checker: watches the request and response channels,
// predicts each string's epoch seconds and valid flag, and compares every response.
// Depends on ists_pkg and ists_if.

module iso_timestamp_to_epoch_seconds_unit_checker
   import ists_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ists_req_if       req_chan,
   ists_rsp_if       rsp_chan,
   output int        mismatch_count,
   output int        stamps_pending,
   output int        stamps_checked
);

   localparam int     FIELD_COUNT    = 6;
   localparam int     PRINT_LIMIT    = 40;
   localparam longint ERA_YEARS      = 400;
   localparam longint ERA_DAYS       = 146097;
   localparam longint EPOCH_DAYS     = 719468;
   localparam longint DAY_SECONDS    = 86400;
   localparam longint HOUR_SECONDS   = 3600;
   localparam longint MINUTE_SECONDS = 60;

   typedef struct packed {
      logic signed [38:0] seconds;
      logic               ok;
   } stamp_result_type;

   // parser state, mirrors what the block has seen of the current string
   logic [4:0]  text_pos;
   logic [13:0] field_mag [FIELD_COUNT];
   logic [5:0]  neg_seen;
   logic        text_bad;

   stamp_result_type expected_stamps [$];

   // which field owns a text position
   function automatic field_type field_at(input logic [4:0] pos);
      int p;
      p = int'(pos);
      if (p < 4) return FLD_YEAR;
      if (p % 3 == 1) return FLD_SEP;
      return field_type'(3'((p + 1) / 3 - 1));
   endfunction

   // first character of a numeric field, the only place a minus may stand
   function automatic logic field_start(input logic [4:0] pos);
      int p;
      p = int'(pos);
      return (p == 0) || (p > 4 && (p + 1) % 3 == 0);
   endfunction

   function automatic logic [7:0] sep_at(input logic [4:0] pos);
      if (pos == 5'd10) return CH_T;
      return (pos < 5'd10) ? CH_MINUS : CH_COLON;
   endfunction

   // proleptic gregorian day count relative to 1970-01-01
   function automatic longint civil_days(input longint yr, input longint mon, input longint dom);
      longint y;
      longint era;
      longint yoe;
      longint doy;
      longint doe;
      y   = (mon <= 2) ? yr - 1 : yr;
      era = (y >= 0 ? y : y - (ERA_YEARS - 1)) / ERA_YEARS;
      yoe = y - era * ERA_YEARS;
      doy = (153 * (mon + (mon > 2 ? -3 : 9)) + 2) / 5 + dom - 1;
      doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      return era * ERA_DAYS + doe - EPOCH_DAYS;
   endfunction

   // result for the string collected so far
   function automatic stamp_result_type stamp_value();
      longint           v [FIELD_COUNT];
      longint           total;
      logic             ok;
      stamp_result_type r;
      for (int i = 0; i < FIELD_COUNT; i++) begin
         v[i] = neg_seen[i] ? -longint'(field_mag[i]) : longint'(field_mag[i]);
      end
      ok = (text_pos >= TS_LEN) && !text_bad;
      if (v[FLD_MONTH] < 1 || v[FLD_MONTH] > 12 || v[FLD_DAY] < 1 || v[FLD_DAY] > 31 ||
          v[FLD_HOUR] < 0 || v[FLD_HOUR] > 23 || v[FLD_MINUTE] < 0 || v[FLD_MINUTE] > 59 ||
          v[FLD_SECOND] < 0 || v[FLD_SECOND] > 60) begin
         ok = 1'b0;
      end
      total = 0;
      if (ok) begin
         total = civil_days(v[FLD_YEAR], v[FLD_MONTH], v[FLD_DAY]) * DAY_SECONDS +
                 v[FLD_HOUR] * HOUR_SECONDS + v[FLD_MINUTE] * MINUTE_SECONDS + v[FLD_SECOND];
      end
      r.seconds = total[38:0];
      r.ok      = ok;
      return r;
   endfunction

   task automatic clear_text();
      text_pos = '0;
      neg_seen = '0;
      text_bad = 1'b0;
      for (int i = 0; i < FIELD_COUNT; i++) field_mag[i] = '0;
   endtask

   // one accepted character; the last one queues the expected result
   task automatic absorb_char(input logic [7:0] ch, input logic is_last);
      field_type fld;
      int        idx;
      int        grown;
      if (text_pos < TS_LEN) begin
         fld = field_at(text_pos);
         idx = int'(fld);
         if (fld == FLD_SEP) begin
            if (ch != sep_at(text_pos)) text_bad = 1'b1;
         end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
            grown = int'(field_mag[idx]) * 10 + int'(ch - CH_ZERO);
            field_mag[idx] = (fld == FLD_YEAR) ? grown[13:0] : {7'd0, grown[6:0]};
         end else if (ch == CH_MINUS && field_start(text_pos)) begin
            neg_seen[idx] = 1'b1;
         end else begin
            text_bad = 1'b1;
         end
         text_pos = text_pos + 5'd1;
      end
      if (is_last) begin
         expected_stamps.push_back(stamp_value());
         clear_text();
      end
   endtask

   task automatic report_mismatch(input string what);
      if (mismatch_count < PRINT_LIMIT) $display("%0d ns mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   // sample both channels at each edge, predict and compare
   always @(posedge clock) begin : monitor
      stamp_result_type want;
      if (reset) begin
         clear_text();
         expected_stamps.delete();
         mismatch_count = 0;
         stamps_checked = 0;
      end else begin
         if (req_chan.valid && req_chan.ready) absorb_char(req_chan.char_code, req_chan.last);
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_stamps.size() == 0) begin
               report_mismatch($sformatf("response with no string pending: seconds %0d valid %0b",
                                         rsp_chan.epoch_seconds, rsp_chan.valid_res));
            end else begin
               want = expected_stamps.pop_front();
               if (rsp_chan.epoch_seconds !== want.seconds) begin
                  report_mismatch($sformatf("epoch_seconds %0d, predicted %0d",
                                            rsp_chan.epoch_seconds, want.seconds));
               end
               if (rsp_chan.valid_res !== want.ok) begin
                  report_mismatch($sformatf("valid_res %b, predicted %b (seconds %0d)",
                                            rsp_chan.valid_res, want.ok, want.seconds));
               end
               stamps_checked++;
            end
         end
      end
      stamps_pending <= expected_stamps.size();
   end

endmodule

// ===== tb/iso_timestamp_to_epoch_seconds_unit_test.sv =====
`timescale 1ns / 1ps
// iso_timestamp_to_epoch_seconds_unit_test: drives timestamp strings and response back-pressure
// into the unit and gives the verdict. Depends on ists_pkg, ists_if, the unit and its checker.

module iso_timestamp_to_epoch_seconds_unit_test
   import ists_pkg::*;
();

   localparam int HALF_PERIOD      = 5;
   localparam int RESET_CYCLES     = 7;
   localparam int CYCLE_LIMIT      = 200000;
   localparam int TAIL_CYCLES      = 40;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int BURST_STRINGS    = 24;
   localparam int PHASE_CHARS      = 50;

   logic clock = 1'b0;
   logic reset;

   ists_req_if req_chan ();
   ists_rsp_if rsp_chan ();

   int mismatch_count;
   int stamps_pending;
   int stamps_checked;

   int send_idle_pct;
   int recv_idle_pct;
   int hold_requests;
   int strings_sent;
   int chars_sent;
   int cycle_count;

   logic [7:0] text_buf [$];

   iso_timestamp_to_epoch_seconds_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   iso_timestamp_to_epoch_seconds_unit_checker i_stamp_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .mismatch_count (mismatch_count),
      .stamps_pending (stamps_pending),
      .stamps_checked (stamps_checked)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("cycle limit reached with %0d strings still pending", stamps_pending);
         $display("FAILED: results differ");
         $finish;
      end
   end

   // response back-pressure, with a long hold on request from the stimulus
   initial begin : receiver
      int hold_left;
      int hold_taken;
      hold_left  = 0;
      hold_taken = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_taken != hold_requests) begin
            hold_taken = hold_requests;
            hold_left  = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // one character request, with a random idle gap in front of it
   task automatic send_char(input logic [7:0] ch, input logic is_last);
      int gap;
      gap = 0;
      if ($urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 4);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= ch;
      req_chan.last      <= is_last;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      chars_sent++;
   endtask

   task automatic send_text();
      foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
      strings_sent++;
   endtask

   // sender pause until every predicted result has come back
   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (stamps_pending != 0) @(posedge clock);
   endtask

   // fixed-width decimal field, minus taking the first place when set
   function automatic void put_field(input int unsigned mag, input int digits, input logic neg);
      int unsigned scale;
      if (neg) begin
         text_buf.push_back(CH_MINUS);
         digits--;
      end
      scale = 1;
      repeat (digits - 1) scale *= 10;
      repeat (digits) begin
         text_buf.push_back(CH_ZERO + 8'((mag / scale) % 10));
         scale /= 10;
      end
   endfunction

   function automatic void build_stamp(input int unsigned yr, input int unsigned mo,
                                       input int unsigned dd, input int unsigned hh,
                                       input int unsigned mi, input int unsigned ss,
                                       input logic [5:0] neg);
      text_buf.delete();
      put_field(yr, 4, neg[FLD_YEAR]);
      text_buf.push_back(CH_MINUS);
      put_field(mo, 2, neg[FLD_MONTH]);
      text_buf.push_back(CH_MINUS);
      put_field(dd, 2, neg[FLD_DAY]);
      text_buf.push_back(CH_T);
      put_field(hh, 2, neg[FLD_HOUR]);
      text_buf.push_back(CH_COLON);
      put_field(mi, 2, neg[FLD_MINUTE]);
      text_buf.push_back(CH_COLON);
      put_field(ss, 2, neg[FLD_SECOND]);
   endfunction

   function automatic void put_noise(input int count);
      repeat (count) text_buf.push_back(8'($urandom_range(255)));
   endfunction

   // well-formed layout with random content, sometimes out of range or signed
   function automatic void random_stamp();
      int unsigned mag [6];
      logic [5:0]  neg;
      logic        wide;
      int          idx;
      wide = ($urandom_range(99) < 10);
      neg  = '0;
      if ($urandom_range(99) < 15) neg[FLD_YEAR] = 1'b1;
      mag[FLD_YEAR]   = neg[FLD_YEAR] ? $urandom_range(999) : $urandom_range(9999);
      mag[FLD_MONTH]  = wide ? $urandom_range(99) : $urandom_range(1, 12);
      mag[FLD_DAY]    = wide ? $urandom_range(99) : $urandom_range(1, 31);
      mag[FLD_HOUR]   = wide ? $urandom_range(99) : $urandom_range(23);
      mag[FLD_MINUTE] = wide ? $urandom_range(99) : $urandom_range(59);
      mag[FLD_SECOND] = wide ? $urandom_range(99) : $urandom_range(60);
      if ($urandom_range(99) < 6) begin
         idx      = $urandom_range(1, 5);
         neg[idx] = 1'b1;
         mag[idx] = $urandom_range(9);
      end
      build_stamp(mag[0], mag[1], mag[2], mag[3], mag[4], mag[5], neg);
   endfunction

   // mixed random strings until the phase has sent its share of characters
   task automatic run_random(input int char_target);
      int start;
      int kind;
      int keep;
      start = chars_sent;
      while (chars_sent - start < char_target) begin
         kind = $urandom_range(99);
         random_stamp();
         if (kind >= 95) begin
            text_buf.delete();
            put_noise($urandom_range(1, 25));
         end else if (kind >= 88) begin
            keep = $urandom_range(1, TS_LEN - 1);
            while (text_buf.size() > keep) void'(text_buf.pop_back());
         end else if (kind >= 80) begin
            put_noise($urandom_range(1, 5));
         end else if (kind >= 65) begin
            keep = $urandom_range(TS_LEN - 1);
            case ($urandom_range(3))
               0:       text_buf[keep] = CH_MINUS;
               1:       text_buf[keep] = CH_COLON;
               2:       text_buf[keep] = CH_T;
               default: text_buf[keep] = 8'($urandom_range(255));
            endcase
         end
         send_text();
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.char_code = 8'h00;
      req_chan.last      = 1'b0;
      send_idle_pct      = 0;
      recv_idle_pct      = 0;
      hold_requests      = 0;
      strings_sent       = 0;
      chars_sent         = 0;
      cycle_count        = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: epoch, extremes, leap day, signed fields
      build_stamp(1970, 1, 1, 0, 0, 0, 6'b000000);   send_text();
      build_stamp(9999, 12, 31, 23, 59, 60, 6'b000000); send_text();
      build_stamp(999, 1, 1, 0, 0, 0, 6'b000001);    send_text();
      build_stamp(2000, 2, 29, 12, 34, 56, 6'b000000); send_text();
      build_stamp(1, 2, 28, 23, 59, 59, 6'b000001);  send_text();
      build_stamp(0, 3, 1, 0, 0, 0, 6'b000000);      send_text();
      build_stamp(2020, 1, 1, 0, 0, 0, 6'b001000);   send_text();
      build_stamp(2020, 1, 1, 0, 0, 0, 6'b000010);   send_text();
      build_stamp(2020, 1, 1, 5, 0, 0, 6'b001000);   send_text();
      // directed: range bounds just outside, all but month zero
      build_stamp(2021, 13, 1, 0, 0, 0, 6'b000000);  send_text();
      build_stamp(2021, 1, 0, 0, 0, 0, 6'b000000);   send_text();
      build_stamp(2021, 1, 32, 0, 0, 0, 6'b000000);  send_text();
      build_stamp(2021, 1, 1, 24, 0, 0, 6'b000000);  send_text();
      build_stamp(2021, 1, 1, 0, 60, 0, 6'b000000);  send_text();
      build_stamp(2021, 1, 1, 0, 0, 61, 6'b000000);  send_text();
      // directed: short text, trailing bytes, broken separator, digit and minus
      text_buf.delete(); text_buf.push_back(8'hFF); send_text();
      build_stamp(1999, 12, 31, 23, 59, 59, 6'b000000);
      while (text_buf.size() > 12) void'(text_buf.pop_back());
      send_text();
      build_stamp(2038, 1, 19, 3, 14, 7, 6'b000000);
      text_buf.push_back(8'h5A); text_buf.push_back(8'hFF); text_buf.push_back(8'h00);
      send_text();
      build_stamp(2001, 9, 9, 1, 46, 40, 6'b000000); text_buf[10] = 8'h20; send_text();
      build_stamp(2001, 9, 9, 1, 46, 40, 6'b000000); text_buf[2] = 8'h61;  send_text();
      build_stamp(2001, 9, 9, 1, 46, 40, 6'b000000); text_buf[1] = CH_MINUS; send_text();
      build_stamp(2001, 9, 9, 1, 46, 40, 6'b000000); text_buf[13] = CH_MINUS; send_text();
      wait_drained();

      // sender mostly busy, receiver mostly stalled
      send_idle_pct = 9;
      recv_idle_pct = 80;
      run_random(PHASE_CHARS);
      wait_drained();

      // sender mostly idle, receiver mostly ready
      send_idle_pct = 80;
      recv_idle_pct = 9;
      run_random(PHASE_CHARS);
      wait_drained();

      // no idling; a long receiver hold first so the date queue fills and stalls input
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      repeat (BURST_STRINGS) begin
         text_buf.delete();
         put_noise($urandom_range(1, 3));
         send_text();
      end
      run_random(PHASE_CHARS);
      wait_drained();

      repeat (TAIL_CYCLES) @(posedge clock);
      $display("sent %0d strings in %0d character requests; %0d results compared",
               strings_sent, chars_sent, stamps_checked);
      $display("covered range limits, signed fields, short and overlong text and back-pressure");
      if (mismatch_count == 0 && stamps_pending == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
